// ===== rtl/core/lpht_pkg.sv =====
// Shared types and constants for the linear probing hash table.
// No dependencies; imported by every module of the block.
package lpht_pkg;

    // Fixed field widths of the item ports
    localparam int DATA_W = 64;
    localparam int SLOT_W = 6;

    // Byte skipped by the home slot sum
    localparam logic [7:0] BLANK_BYTE = 8'h20;

    // Operation codes on the mode field
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // Result codes on the status field
    typedef enum logic [1:0] {
        ST_STORED    = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Access request from the sequencer to the slot store
    typedef struct packed {
        logic rd;       // read the slot at the read address
        logic wr;       // write the slot at the write address
        logic wr_used;  // used flag written with the entry
    } t_store_cmd;

endpackage

// ===== rtl/core/lpht_hash.sv =====
// Home slot unit: sums the key bytes one per cycle, skipping zero and blank
// bytes, then reduces the sum modulo (TABLE_SIZE-1) with a reciprocal
// multiply and one compare/subtract, and adds one. Depends on lpht_pkg.
module lpht_hash
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 64,
    parameter int KEY_CHARS  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [8*KEY_CHARS-1:0]        i_key,
    output logic                          o_done,
    output logic [$clog2(TABLE_SIZE)-1:0] o_home
);

    localparam int KEY_W  = 8 * KEY_CHARS;
    localparam int AW     = $clog2(TABLE_SIZE);
    localparam int SUM_W  = $clog2(KEY_CHARS * 255 + 1);
    localparam int CW     = $clog2(KEY_CHARS + 1);
    localparam int RCP_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam int EW     = SUM_W + AW + 1;
    // floor(2^SUM_W / divisor): the quotient estimate is exact or one low
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((2 ** SUM_W) / (TABLE_SIZE - 1));
    localparam logic [EW-1:0]    DIV   = EW'(TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        H_IDLE,
        H_ACC,
        H_MUL,
        H_SUB,
        H_FIX
    } t_hstate;

    t_hstate           r_state;
    logic [KEY_W-1:0]  r_key;
    logic [SUM_W-1:0]  r_sum;
    logic [RCP_W-1:0]  r_quot;
    logic [EW-1:0]     r_diff;
    logic [AW-1:0]     r_rem;
    logic [CW-1:0]     r_cnt;
    logic              r_done;

    logic [7:0]        w_byte;
    logic              w_take;
    logic [PROD_W-1:0] w_prod;
    logic [EW-1:0]     w_diff;
    logic              w_ge;

    // Byte test, quotient estimate, remainder and its correction test
    always_comb begin
        w_byte = r_key[7:0];
        w_take = (w_byte != 8'd0) && (w_byte != BLANK_BYTE);
        w_prod = PROD_W'(r_sum) * PROD_W'(RECIP);
        w_diff = EW'(r_sum) - EW'(r_quot) * DIV;
        w_ge   = (r_diff >= DIV);
    end

    // Sequence the accumulate and reduce steps
    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            unique case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_key   <= i_key;
                        r_sum   <= '0;
                        r_cnt   <= CW'(KEY_CHARS - 1);
                        r_state <= H_ACC;
                    end
                end
                H_ACC: begin
                    if (w_take) begin
                        r_sum <= r_sum + SUM_W'(w_byte);
                    end
                    r_key <= r_key >> 8;
                    if (r_cnt == '0) begin
                        r_state <= H_MUL;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                H_MUL: begin
                    r_quot  <= w_prod[PROD_W-1:SUM_W];
                    r_state <= H_SUB;
                end
                H_SUB: begin
                    r_diff  <= w_diff;
                    r_state <= H_FIX;
                end
                H_FIX: begin
                    // remainder is below twice the divisor, fold it once
                    r_rem   <= w_ge ? AW'(r_diff - DIV) : AW'(r_diff);
                    r_done  <= 1'b1;
                    r_state <= H_IDLE;
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_home = r_rem + AW'(1);

endmodule

// ===== rtl/core/lpht_store.sv =====
// Slot store: used flag, key and value memories with one write port and
// one registered read port. Depends on lpht_pkg.
module lpht_store
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 64,
    parameter int KEY_W      = 64
) (
    input  logic                          i_clk,
    input  t_store_cmd                    i_cmd,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_rd_addr,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_wr_addr,
    input  logic [KEY_W-1:0]              i_wr_key,
    input  logic [DATA_W-1:0]             i_wr_value,
    output logic                          o_rd_used,
    output logic [KEY_W-1:0]              o_rd_key,
    output logic [DATA_W-1:0]             o_rd_value
);

    logic              r_used_mem  [TABLE_SIZE];
    logic [KEY_W-1:0]  r_key_mem   [TABLE_SIZE];
    logic [DATA_W-1:0] r_value_mem [TABLE_SIZE];

    logic              r_rd_used;
    logic [KEY_W-1:0]  r_rd_key;
    logic [DATA_W-1:0] r_rd_value;

    // Write one slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_used_mem[i_wr_addr]  <= i_cmd.wr_used;
            r_key_mem[i_wr_addr]   <= i_wr_key;
            r_value_mem[i_wr_addr] <= i_wr_value;
        end
    end

    // Read one slot, data registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_used  <= r_used_mem[i_rd_addr];
            r_rd_key   <= r_key_mem[i_rd_addr];
            r_rd_value <= r_value_mem[i_rd_addr];
        end
    end

    assign o_rd_used  = r_rd_used;
    assign o_rd_key   = r_rd_key;
    assign o_rd_value = r_rd_value;

endmodule

// ===== rtl/core/linear_probe_hash_table_top.sv =====
// Linear probing hash table: sequencer, probe compare and output register.
// Depends on lpht_pkg, lpht_hash and lpht_store.
//
//  channel  valid        stall        payload
//  -------  -----------  -----------  ----------------------------------
//  input    i_in_valid   o_in_stall   i_mode, i_key, i_entry_value
//  output   o_out_valid  i_out_stall  o_status, o_slot, o_found_value
//
// An item is hashed (one key byte per cycle, then multiply, subtract, correct),
// then probed slot after slot from its home slot through the registered slot
// read, and handed over through the output register.
// After reset a clearing pass marks every slot unused, with o_in_stall
// high throughout. A result waits in the output register while the
// next item is taken; a finished item holds only if that register is full.
module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 64,
    parameter int KEY_CHARS  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_mode,
    input  logic [DATA_W-1:0] i_key,
    input  logic [DATA_W-1:0] i_entry_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [SLOT_W-1:0] o_slot,
    output logic [DATA_W-1:0] o_found_value
);

    localparam int KEY_W = 8 * KEY_CHARS;
    localparam int AW    = $clog2(TABLE_SIZE);
    localparam int CNTW  = $clog2(TABLE_SIZE + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FINISH
    } t_state;

    t_state            r_state;
    logic              r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_value;
    logic [AW-1:0]     r_addr;
    logic [CNTW-1:0]   r_issued;
    logic [CNTW-1:0]   r_checked;
    logic              r_pend;
    logic [AW-1:0]     r_pend_slot;
    t_status           r_res_status;
    logic [AW-1:0]     r_res_slot;
    logic [DATA_W-1:0] r_res_value;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [SLOT_W-1:0] r_out_slot;
    logic [DATA_W-1:0] r_out_value;

    logic              w_in_acc;
    logic              w_out_take;
    logic              w_out_load;
    logic              w_hash_done;
    logic [AW-1:0]     w_home;
    logic              w_rd_used;
    logic [KEY_W-1:0]  w_rd_key;
    logic [DATA_W-1:0] w_rd_value;
    logic              w_hit;
    logic              w_last;
    logic              w_issue;
    logic [AW-1:0]     w_next;
    t_store_cmd        w_cmd;
    logic [AW-1:0]     w_wr_addr;

    // Home slot unit
    lpht_hash #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_CHARS  (KEY_CHARS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_key   (i_key[KEY_W-1:0]),
        .o_done  (w_hash_done),
        .o_home  (w_home)
    );

    // Slot memories
    lpht_store #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_W      (KEY_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_rd_addr  (r_addr),
        .i_wr_addr  (w_wr_addr),
        .i_wr_key   (r_key),
        .i_wr_value (r_value),
        .o_rd_used  (w_rd_used),
        .o_rd_key   (w_rd_key),
        .o_rd_value (w_rd_value)
    );

    // Handshakes
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_out_load = (r_state == S_FINISH) && (!r_out_valid || w_out_take);

    // Probe compare, wrap and store requests
    always_comb begin
        w_next = (r_addr == AW'(TABLE_SIZE - 1)) ? '0 : r_addr + AW'(1);
        if (r_mode == MODE_INSERT) begin
            w_hit = r_pend && !w_rd_used;
        end else begin
            w_hit = r_pend && w_rd_used && (w_rd_key == r_key);
        end
        w_last  = r_pend && (r_checked == CNTW'(TABLE_SIZE - 1));
        w_issue = (r_state == S_PROBE) && !w_hit && (r_issued != CNTW'(TABLE_SIZE));

        w_cmd.rd      = w_issue;
        w_cmd.wr      = (r_state == S_CLEAR)
                        || ((r_state == S_PROBE) && w_hit && (r_mode == MODE_INSERT));
        w_cmd.wr_used = (r_state == S_PROBE);
        w_wr_addr     = (r_state == S_CLEAR) ? r_addr : r_pend_slot;
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= w_next;
                    if (r_addr == AW'(TABLE_SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_mode  <= i_mode;
                        r_key   <= i_key[KEY_W-1:0];
                        r_value <= i_entry_value;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_addr    <= w_home;
                        r_issued  <= '0;
                        r_checked <= '0;
                        r_pend    <= 1'b0;
                        r_state   <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    r_pend      <= w_issue;
                    r_pend_slot <= r_addr;
                    if (w_issue) begin
                        r_addr   <= w_next;
                        r_issued <= r_issued + CNTW'(1);
                    end
                    if (r_pend) begin
                        r_checked <= r_checked + CNTW'(1);
                    end
                    if (w_hit) begin
                        r_res_slot <= r_pend_slot;
                        if (r_mode == MODE_INSERT) begin
                            r_res_status <= ST_STORED;
                            r_res_value  <= '0;
                        end else begin
                            r_res_status <= ST_FOUND;
                            r_res_value  <= w_rd_value;
                        end
                        r_state <= S_FINISH;
                    end else if (w_last) begin
                        r_res_status <= (r_mode == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
                        r_res_slot   <= '0;
                        r_res_value  <= '0;
                        r_state      <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // hand over once the output register is free
                    if (w_out_load) begin
                        r_out_status <= r_res_status;
                        r_out_slot   <= SLOT_W'(r_res_slot);
                        r_out_value  <= r_res_value;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot        = r_out_slot;
    assign o_found_value = r_out_value;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the linear probing hash table.
// Depends on lpht_pkg and linear_probe_hash_table_top; runs a directed table,
// then random inserts and lookups, checked against an in-bench table model.
`timescale 1ns / 1ps

module tb_top
    import lpht_pkg::*;
();

    localparam int TABLE_SIZE   = 64;
    localparam int KEY_CHARS    = 8;
    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 6;
    localparam int RAND_ITEMS   = 950;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AFTER   = 40;
    localparam int DRAIN_CYCLES = 100;
    localparam longint TIMEOUT_NS = 64'd8_000_000;
    localparam logic [DATA_W-1:0] KEY_MASK = {DATA_W{1'b1}} >> (64 - 8 * KEY_CHARS);
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    typedef struct {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] value;
    } table_reply_t;

    typedef struct {
        logic              mode;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        bit                typed;
        table_reply_t      want;
    } table_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_mode;
    logic [DATA_W-1:0] i_key;
    logic [DATA_W-1:0] i_entry_value;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [1:0]        o_status;
    logic [SLOT_W-1:0] o_slot;
    logic [DATA_W-1:0] o_found_value;

    // Table model state
    logic              slot_taken [TABLE_SIZE];
    logic [DATA_W-1:0] stored_key [TABLE_SIZE];
    logic [DATA_W-1:0] stored_val [TABLE_SIZE];
    int unsigned       slots_filled = 0;

    table_reply_t      pending_replies [$];
    table_row_t        dir_rows [$];
    logic [DATA_W-1:0] known_keys [$];
    int unsigned       mismatch_cnt = 0;
    int unsigned       replies_seen = 0;
    int unsigned       burst_left = 0;

    linear_probe_hash_table_top #(
        .TABLE_SIZE(TABLE_SIZE),
        .KEY_CHARS (KEY_CHARS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .i_entry_value(i_entry_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_found_value(o_found_value)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
            slot_taken[i] = 1'b0;
            stored_key[i] = '0;
            stored_val[i] = '0;
        end
    end

    task automatic note_mismatch(input string what);
        mismatch_cnt++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Apply one insert or lookup to the table model and return its reply
    function automatic table_reply_t apply_table_op(input logic mode,
                                                    input logic [DATA_W-1:0] key,
                                                    input logic [DATA_W-1:0] value);
        table_reply_t      r;
        logic [DATA_W-1:0] k;
        logic [7:0]        ch;
        int unsigned       sum;
        int unsigned       s;
        bit                done;
        k = key & KEY_MASK;
        sum = 0;
        for (int i = 0; i < KEY_CHARS; i++) begin
            ch = k[8*i +: 8];
            if (ch != 8'h00 && ch != BLANK_BYTE) sum += ch;
        end
        s = sum % (TABLE_SIZE - 1) + 1;
        r.status = (mode == MODE_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
        r.slot = '0;
        r.value = '0;
        done = 1'b0;
        for (int n = 0; n < TABLE_SIZE; n++) begin
            if (!done) begin
                if (mode == MODE_INSERT) begin
                    if (!slot_taken[s]) begin
                        slot_taken[s] = 1'b1;
                        stored_key[s] = k;
                        stored_val[s] = value;
                        slots_filled++;
                        r.status = ST_STORED;
                        r.slot = s[SLOT_W-1:0];
                        done = 1'b1;
                    end
                end else if (slot_taken[s] && stored_key[s] == k) begin
                    r.status = ST_FOUND;
                    r.slot = s[SLOT_W-1:0];
                    r.value = stored_val[s];
                    done = 1'b1;
                end
                s = (s < TABLE_SIZE - 1) ? s + 1 : 0;
            end
        end
        return r;
    endfunction

    // Queue a directed row; typed rows carry their own expected reply
    task automatic add_row(input logic mode, input logic [DATA_W-1:0] key,
                           input logic [DATA_W-1:0] value, input bit typed,
                           input t_status st, input int unsigned slot,
                           input logic [DATA_W-1:0] fv);
        table_row_t row;
        row.mode = mode;
        row.key = key;
        row.value = value;
        row.typed = typed;
        row.want.status = st;
        row.want.slot = slot[SLOT_W-1:0];
        row.want.value = fv;
        dir_rows.push_back(row);
    endtask

    // Build a random key in one of several shapes
    function automatic logic [DATA_W-1:0] make_key();
        logic [DATA_W-1:0] k;
        logic [7:0]        t;
        int unsigned       nb;
        int unsigned       a;
        int unsigned       b;
        k = '0;
        case ($urandom_range(0, 4))
            0: k = {$urandom, $urandom};
            1: begin
                // printable name, zero padded
                nb = $urandom_range(1, KEY_CHARS);
                for (int i = 0; i < nb; i++) k[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
            end
            2: begin
                // spaces and zero bytes mixed in
                for (int i = 0; i < KEY_CHARS; i++) begin
                    case ($urandom_range(0, 3))
                        0: k[8*i +: 8] = 8'h00;
                        1: k[8*i +: 8] = BLANK_BYTE;
                        default: k[8*i +: 8] = 8'($urandom_range(0, 255));
                    endcase
                end
            end
            3: begin
                // swap two bytes of a known key: same home, a different key unless the bytes match
                if (known_keys.size() != 0) begin
                    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                    a = $urandom_range(0, KEY_CHARS - 1);
                    b = $urandom_range(0, KEY_CHARS - 1);
                    t = k[8*a +: 8];
                    k[8*a +: 8] = k[8*b +: 8];
                    k[8*b +: 8] = t;
                end else begin
                    k = {$urandom, $urandom};
                end
            end
            default: begin
                k[8*$urandom_range(0, KEY_CHARS - 1) +: 8] = 8'($urandom_range(0, 255));
            end
        endcase
        return k;
    endfunction

    // Offer one item in bursts with random gaps, wait for it to be taken
    task automatic offer_item(input table_row_t row);
        int unsigned  gap;
        table_reply_t pred;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    gap = 0;
                    burst_left = $urandom_range(20, 60);
                end
                8, 9: begin
                    gap = $urandom_range(20, 120);
                    burst_left = $urandom_range(1, 6);
                end
                default: begin
                    gap = $urandom_range(1, 6);
                    burst_left = $urandom_range(1, 12);
                end
            endcase
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_mode        <= row.mode;
        i_key         <= row.key;
        i_entry_value <= row.value;
        do @(posedge i_clk); while (o_in_stall);
        pred = apply_table_op(row.mode, row.key, row.value);
        pending_replies.push_back(row.typed ? row.want : pred);
    endtask

    // Stimulus: reset, directed table, random part, drain
    initial begin : drive_items
        table_row_t  row;
        int unsigned ins_pct;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_INSERT;
        i_key         = '0;
        i_entry_value = '0;

        // empty key, duplicates, extremes of key and value
        add_row(MODE_LOOKUP, 64'h0, 64'h0, 1, ST_NOT_FOUND, 0, 64'h0);
        add_row(MODE_INSERT, 64'h0, ALL_ONES, 1, ST_STORED, 1, 64'h0);
        add_row(MODE_LOOKUP, 64'h0, 64'h0, 1, ST_FOUND, 1, ALL_ONES);
        add_row(MODE_INSERT, 64'h0, 64'h0, 1, ST_STORED, 2, 64'h0);
        add_row(MODE_LOOKUP, 64'h0, ALL_ONES, 1, ST_FOUND, 1, ALL_ONES);
        add_row(MODE_INSERT, ALL_ONES, 64'h0, 1, ST_STORED, 25, 64'h0);
        add_row(MODE_LOOKUP, ALL_ONES, ALL_ONES, 1, ST_FOUND, 25, 64'h0);
        // all spaces hash like the empty key
        add_row(MODE_INSERT, 64'h2020202020202020, 64'hAAAAAAAAAAAAAAAA, 0, ST_STORED, 0, 0);
        // home on the top slot, then wrap to slot zero
        add_row(MODE_INSERT, 64'h3E, 64'h5555555555555555, 0, ST_STORED, 0, 0);
        add_row(MODE_INSERT, 64'h3E, 64'h0123456789ABCDEF, 0, ST_STORED, 0, 0);
        add_row(MODE_LOOKUP, 64'h3E, 64'h0, 0, ST_STORED, 0, 0);
        add_row(MODE_INSERT, 64'h3F, 64'hFEDCBA9876543210, 0, ST_STORED, 0, 0);
        // zero bytes inside a key: same sum, different bits
        add_row(MODE_INSERT, 64'h4100, 64'h8000000000000001, 0, ST_STORED, 0, 0);
        add_row(MODE_LOOKUP, 64'h41, 64'h0, 0, ST_STORED, 0, 0);
        add_row(MODE_LOOKUP, 64'h4100, 64'h0, 0, ST_STORED, 0, 0);
        add_row(MODE_INSERT, 64'h636261, 64'h00000000FFFFFFFF, 0, ST_STORED, 0, 0);
        add_row(MODE_LOOKUP, 64'h2020202020202020, 64'h0, 0, ST_STORED, 0, 0);
        add_row(MODE_LOOKUP, 64'h20, 64'h0, 0, ST_STORED, 0, 0);
        add_row(MODE_LOOKUP, 64'h8000000000000000, 64'h0, 0, ST_STORED, 0, 0);
        add_row(MODE_INSERT, 64'h8000000000000000, ALL_ONES, 0, ST_STORED, 0, 0);
        add_row(MODE_LOOKUP, 64'h8000000000000000, 64'h0, 0, ST_STORED, 0, 0);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) offer_item(dir_rows[i]);

        // Random part: fill the table, then keep probing it full
        for (int n = 0; n < RAND_ITEMS; n++) begin
            ins_pct = (slots_filled < TABLE_SIZE) ? 25 : 8;
            row.typed = 1'b0;
            if ($urandom_range(0, 99) < ins_pct) begin
                row.mode = MODE_INSERT;
                if (known_keys.size() != 0 && $urandom_range(0, 9) < 2)
                    row.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else
                    row.key = make_key();
                known_keys.push_back(row.key);
            end else begin
                row.mode = MODE_LOOKUP;
                if (known_keys.size() != 0 && $urandom_range(0, 9) < 6)
                    row.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else
                    row.key = make_key();
            end
            case ($urandom_range(0, 9))
                0: row.value = '0;
                1: row.value = ALL_ONES;
                default: row.value = {$urandom, $urandom};
            endcase
            offer_item(row);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain outstanding replies, then let the block settle
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Receiver stall patterns, with one long hold-off to back the block up
    initial begin : stall_replies
        bit          hold_done;
        int unsigned style;
        int unsigned len;
        i_out_stall = 1'b0;
        hold_done = 1'b0;
        forever begin
            if (!hold_done && replies_seen >= HOLD_AFTER) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                style = $urandom_range(0, 2);
                len = $urandom_range(1, 60);
                repeat (len) begin
                    @(negedge i_clk);
                    case (style)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= ($urandom_range(0, 1) != 0);
                        default: i_out_stall <= ($urandom_range(0, 9) < 8);
                    endcase
                end
            end
        end
    end

    // Compare each taken result with the oldest expected reply
    always @(posedge i_clk) begin : check_replies
        table_reply_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
                note_mismatch("result with nothing expected");
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status)
                    note_mismatch($sformatf("status got %0d want %0d", o_status, want.status));
                if (o_slot !== want.slot)
                    note_mismatch($sformatf("slot got %0d want %0d", o_slot, want.slot));
                if (o_found_value !== want.value)
                    note_mismatch($sformatf("value got %h want %h", o_found_value, want.value));
            end
        end
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
